FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pal_pkg.sv
package pal_pkg;

    // Field widths of the stream items
    localparam int LOAD_INDEX_W = 4;
    localparam int IN_SIZE_W    = 16;
    localparam int OUT_INDEX_W  = 4;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 8;
    localparam int M_TUSER_W    = 1;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int POLICY_W = 2;
    localparam int PCOUNT_W = 5;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } pal_state_t;

    typedef struct packed {
        logic accept_load;
        logic accept_req;
        logic issue;
        logic finish;
    } pal_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic issue_last;
        logic out_full;
    } pal_status_t;

endpackage

FILE: rtl/core/pal_apb_regs.sv
module pal_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pal_pkg::PADDR_W-1:0]   paddr,
    input  logic [pal_pkg::PDATA_W-1:0]   pwdata,
    output logic [pal_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [pal_pkg::POLICY_W-1:0]  policy_mode,
    output logic [pal_pkg::PCOUNT_W-1:0]  partition_count
);
    import pal_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [POLICY_W-1:0] policy_next;
    logic [PCOUNT_W-1:0] count_reg;
    logic [PCOUNT_W-1:0] count_next;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        policy_next = policy_reg;
        count_next  = count_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_POLICY: policy_next = pwdata[POLICY_W-1:0];
                REG_COUNT:  count_next  = pwdata[PCOUNT_W-1:0];
                default:    policy_next = policy_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIRST;
            count_reg  <= '0;
        end else begin
            policy_reg <= policy_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_POLICY: prdata = {{(PDATA_W-POLICY_W){1'b0}}, policy_reg};
            REG_COUNT:  prdata = {{(PDATA_W-PCOUNT_W){1'b0}}, count_reg};
            default:    prdata = '0;
        endcase
    end

    assign policy_mode     = policy_reg;
    assign partition_count = count_reg;

endmodule

FILE: rtl/core/pal_datapath.sv
`include "assert_macros.svh"

module pal_datapath #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pal_pkg::pal_cmd_t                cmd,
    output pal_pkg::pal_status_t             status,
    input  logic [pal_pkg::POLICY_W-1:0]     policy_mode,
    input  logic [pal_pkg::PCOUNT_W-1:0]     partition_count,
    input  logic [pal_pkg::LOAD_INDEX_W-1:0] load_index,
    input  logic [pal_pkg::IN_SIZE_W-1:0]    partition_size,
    input  logic [pal_pkg::IN_SIZE_W-1:0]    request_size,
    input  logic                             restart,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic                             m_granted,
    output logic [pal_pkg::OUT_INDEX_W-1:0]  m_granted_index
);
    import pal_pkg::*;

    localparam int IDX_W = $clog2(PARTITIONS);
    localparam int CNT_W = $clog2(PARTITIONS + 1);

    logic [SIZE_BITS-1:0] size_mem [PARTITIONS];

    logic [PARTITIONS-1:0] used_reg, used_next;
    logic [IDX_W-1:0]      next_start_reg, next_start_next;
    logic [SIZE_BITS-1:0]  need_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic [SIZE_BITS-1:0]  rd_reg;
    logic [IDX_W-1:0]      pidx_reg;
    logic                  pvld_reg;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_BITS-1:0]  best_reg, best_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  granted_reg;
    logic [OUT_INDEX_W-1:0] gidx_reg;

    logic [CNT_W-1:0] active_count;
    logic [IDX_W-1:0] scan_start;
    logic             load_ok;
    logic [IDX_W-1:0] load_addr;
    logic             fit;
    logic             better;

    // Clamp the configured count to the table depth
    assign active_count = (32'(partition_count) > PARTITIONS) ? CNT_W'(PARTITIONS)
                                                               : CNT_W'(partition_count);

    assign load_ok   = 32'(load_index) < PARTITIONS;
    assign load_addr = IDX_W'(load_index);

    // Next fit resumes at the last grant; every other policy scans upwards from zero
    always_comb begin
        scan_start = '0;
        if (policy_mode == POL_NEXT && !restart && CNT_W'(next_start_reg) < active_count) begin
            scan_start = next_start_reg;
        end
    end

    assign fit = pvld_reg && !used_reg[pidx_reg] && (rd_reg >= need_reg);

    always_comb begin
        case (policy_mode) inside
            POL_FIRST, POL_NEXT: better = !found_reg;
            POL_BEST:            better = !found_reg || (rd_reg < best_reg);
            POL_WORST:           better = !found_reg || (rd_reg > best_reg);
            default:             better = 1'b0;
        endcase
    end

    always_comb begin
        used_next       = used_reg;
        next_start_next = next_start_reg;
        idx_next        = idx_reg;
        remain_next     = remain_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cmd.accept_req) begin
            if (restart) begin
                used_next       = '0;
                next_start_next = '0;
            end
            idx_next    = scan_start;
            remain_next = active_count;
            found_next  = 1'b0;
        end

        if (cmd.issue) begin
            remain_next = remain_reg - CNT_W'(1);
            idx_next    = (CNT_W'(idx_reg) == active_count - CNT_W'(1)) ? '0
                                                                         : idx_reg + IDX_W'(1);
        end

        if (fit && better) begin
            found_next = 1'b1;
            pick_next  = pidx_reg;
            best_next  = rd_reg;
        end

        if (cmd.finish) begin
            m_valid_next = 1'b1;
            if (found_reg) begin
                used_next[pick_reg] = 1'b1;
                if (policy_mode == POL_NEXT) begin
                    next_start_next = pick_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            next_start_reg <= '0;
            remain_reg     <= '0;
            pvld_reg       <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            used_reg       <= used_next;
            next_start_reg <= next_start_next;
            remain_reg     <= remain_next;
            pvld_reg       <= cmd.issue;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        pick_reg <= pick_next;
        best_reg <= best_next;
        if (cmd.accept_req) begin
            need_reg <= SIZE_BITS'(request_size);
        end
        if (cmd.finish) begin
            granted_reg <= found_reg;
            gidx_reg    <= found_reg ? OUT_INDEX_W'(pick_reg) : '0;
        end
    end

    // Size table: one write port for loads, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (cmd.accept_load && load_ok) begin
            size_mem[load_addr] <= SIZE_BITS'(partition_size);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_reg   <= size_mem[idx_reg];
            pidx_reg <= idx_reg;
        end
    end

    assign status.count_zero = (active_count == '0);
    assign status.issue_last = (remain_reg == CNT_W'(1));
    assign status.out_full   = m_valid_reg && !m_ready;

    assign m_valid         = m_valid_reg;
    assign m_granted       = granted_reg;
    assign m_granted_index = gidx_reg;

    `ASSERT_IMPL(a_refused_index_zero, aclk, aresetn,
        m_valid_reg && !granted_reg, gidx_reg == '0,
        "refused request carries a non-zero index")
    `ASSERT_NEXT(a_grant_marks_used, aclk, aresetn,
        cmd.finish && found_reg, used_reg[$past(pick_reg)],
        "granted partition not marked used")

endmodule

FILE: rtl/core/pal_ctrl.sv
`include "assert_macros.svh"

module pal_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_kind,
    output logic                 s_ready,
    input  pal_pkg::pal_status_t status,
    output pal_pkg::pal_cmd_t    cmd
);
    import pal_pkg::*;

    pal_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_kind == KIND_REQUEST) begin
                    state_next = status.count_zero ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (!status.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.accept_load = s_valid && s_kind == KIND_LOAD;
                cmd.accept_req  = s_valid && s_kind == KIND_REQUEST;
            end
            ST_SCAN:  cmd.issue  = 1'b1;
            ST_DRAIN: cmd.issue  = 1'b0;
            ST_DONE:  cmd.finish = !status.out_full;
            default:  cmd        = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn,
        cmd.finish, !status.out_full,
        "result written over a stalled transaction")
    `ASSERT_NEXT(a_busy_after_request, aclk, aresetn,
        cmd.accept_req, !s_ready,
        "input taken again before the request was served")
    `ASSERT_NEXT(a_idle_after_finish, aclk, aresetn,
        cmd.finish, s_ready,
        "controller not idle after result")

endmodule

FILE: rtl/core/partition_placement_allocator.sv
// Load transaction: accepted while idle, no result.
// Request: after acceptance the size table is read once per active partition (one read per
// cycle), then a drain state and a result state; with no partitions only the result state.
// One request at a time; input reopens with the result, which waits while the output stalls.
// Reset (aresetn low, synchronous): clears the state, used marks, next-fit pointer and the
// result valid flag; the size table is not cleared and must be loaded before use.
module partition_placement_allocator #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: load_index[3:0], partition_size[19:4], request_size[35:20], zero pad
    input  logic [pal_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[0], restart[1]
    input  logic [pal_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: granted_index[3:0], zero pad
    output logic [pal_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: granted[0]
    output logic [pal_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pal_pkg::PADDR_W-1:0]    paddr,
    input  logic [pal_pkg::PDATA_W-1:0]    pwdata,
    output logic [pal_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import pal_pkg::*;

    pal_cmd_t    cmd;
    pal_status_t status;

    logic [POLICY_W-1:0]    policy_mode;
    logic [PCOUNT_W-1:0]    partition_count;
    logic [LOAD_INDEX_W-1:0] load_index;
    logic [IN_SIZE_W-1:0]   partition_size;
    logic [IN_SIZE_W-1:0]   request_size;
    logic                   granted;
    logic [OUT_INDEX_W-1:0] granted_index;

    assign load_index     = s_tdata[LOAD_INDEX_W-1:0];
    assign partition_size = s_tdata[LOAD_INDEX_W +: IN_SIZE_W];
    assign request_size   = s_tdata[LOAD_INDEX_W+IN_SIZE_W +: IN_SIZE_W];

    assign m_tdata = {{(M_TDATA_W-OUT_INDEX_W){1'b0}}, granted_index};
    assign m_tuser = granted;

    pal_apb_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .policy_mode     (policy_mode),
        .partition_count (partition_count)
    );

    pal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_kind  (s_tuser[0]),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pal_datapath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .policy_mode     (policy_mode),
        .partition_count (partition_count),
        .load_index      (load_index),
        .partition_size  (partition_size),
        .request_size    (request_size),
        .restart         (s_tuser[1]),
        .m_ready         (m_tready),
        .m_valid         (m_tvalid),
        .m_granted       (granted),
        .m_granted_index (granted_index)
    );

endmodule
